// ----- design/xksm_pkg.sv -----
// xksm_pkg: shared types, constants and the key template table
// used by the key sequence matcher core and its template walker
package xksm_pkg;

	localparam int unsigned MaxSeqDefault = 16;
	localparam int unsigned NumTemplates = 57;
	localparam int unsigned TemplateLen = 11;
	localparam int unsigned TidxW = 6;
	localparam int unsigned TposW = 4;

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_PARTIAL = 2'd1;
	localparam logic [1:0] ST_MATCH = 2'd2;

	localparam logic [7:0] WILD = 8'h5F;
	localparam logic [7:0] ESC = 8'h1B;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	typedef struct packed {
		logic [1:0] status;
		logic       is_char;
		logic [6:0] code;
		logic [2:0] mods;
		logic [4:0] used;
	} result_t;

	typedef struct packed {
		logic [6:0]  code;
		logic        is_char;
		logic [3:0]  len;
		logic [87:0] chars; // char 0 in bits [7:0]
	} tmpl_t;

	function automatic tmpl_t mk(input logic [6:0] code, input logic is_char,
			input logic [3:0] len, input logic [87:0] s);
		tmpl_t t;
		t.code = code;
		t.is_char = is_char;
		t.len = len;
		t.chars = s;
		return t;
	endfunction

	// byte-packed template from an up to 10 char tail after escape
	function automatic logic [87:0] pk(input logic [79:0] tail, input int unsigned n);
		logic [87:0] r;
		r = '0;
		r[7:0] = ESC;
		for (int i = 0; i < 10; i++) begin
			if (i < n) r[8*(i+1) +: 8] = tail[8*(n-1-i) +: 8];
		end
		return r;
	endfunction

	function automatic tmpl_t tmpl_rom(input logic [TidxW-1:0] k);
		tmpl_t t;
		t = mk(7'd0, 1'b0, 4'd0, '0);
		case (k)
			6'd0: t = mk(7'd0, 1'b0, 4'd6, pk(80'("[1;_P"), 5));
			6'd1: t = mk(7'd0, 1'b0, 4'd6, pk(80'("O1;_P"), 5));
			6'd2: t = mk(7'd0, 1'b0, 4'd4, pk(80'("O_P"), 3));
			6'd3: t = mk(7'd1, 1'b0, 4'd6, pk(80'("[1;_Q"), 5));
			6'd4: t = mk(7'd1, 1'b0, 4'd6, pk(80'("O1;_Q"), 5));
			6'd5: t = mk(7'd1, 1'b0, 4'd4, pk(80'("O_Q"), 3));
			6'd6: t = mk(7'd2, 1'b0, 4'd6, pk(80'("[1;_R"), 5));
			6'd7: t = mk(7'd2, 1'b0, 4'd6, pk(80'("O1;_R"), 5));
			6'd8: t = mk(7'd2, 1'b0, 4'd4, pk(80'("O_R"), 3));
			6'd9: t = mk(7'd3, 1'b0, 4'd6, pk(80'("[1;_S"), 5));
			6'd10: t = mk(7'd3, 1'b0, 4'd6, pk(80'("O1;_S"), 5));
			6'd11: t = mk(7'd3, 1'b0, 4'd4, pk(80'("O_S"), 3));
			6'd12: t = mk(7'd4, 1'b0, 4'd7, pk(80'("[15;_~"), 6));
			6'd13: t = mk(7'd5, 1'b0, 4'd7, pk(80'("[17;_~"), 6));
			6'd14: t = mk(7'd6, 1'b0, 4'd7, pk(80'("[18;_~"), 6));
			6'd15: t = mk(7'd7, 1'b0, 4'd7, pk(80'("[19;_~"), 6));
			6'd16: t = mk(7'd8, 1'b0, 4'd7, pk(80'("[20;_~"), 6));
			6'd17: t = mk(7'd9, 1'b0, 4'd7, pk(80'("[21;_~"), 6));
			6'd18: t = mk(7'd10, 1'b0, 4'd7, pk(80'("[23;_~"), 6));
			6'd19: t = mk(7'd11, 1'b0, 4'd7, pk(80'("[24;_~"), 6));
			6'd20: t = mk(7'd12, 1'b0, 4'd6, pk(80'("[1;_A"), 5));
			6'd21: t = mk(7'd13, 1'b0, 4'd6, pk(80'("[1;_B"), 5));
			6'd22: t = mk(7'd14, 1'b0, 4'd6, pk(80'("[1;_C"), 5));
			6'd23: t = mk(7'd15, 1'b0, 4'd6, pk(80'("[1;_D"), 5));
			6'd24: t = mk(7'd16, 1'b0, 4'd6, pk(80'("[1;_H"), 5));
			6'd25: t = mk(7'd17, 1'b0, 4'd6, pk(80'("[1;_F"), 5));
			6'd26: t = mk(7'd18, 1'b0, 4'd6, pk(80'("[5;_~"), 5));
			6'd27: t = mk(7'd19, 1'b0, 4'd6, pk(80'("[6;_~"), 5));
			6'd28: t = mk(7'd20, 1'b0, 4'd6, pk(80'("[2;_~"), 5));
			6'd29: t = mk(7'd21, 1'b0, 4'd6, pk(80'("[3;_~"), 5));
			6'd30: t = mk(7'h21, 1'b1, 4'd10, pk(80'("[27;_;33~"), 9));
			6'd31: t = mk(7'h23, 1'b1, 4'd10, pk(80'("[27;_;35~"), 9));
			6'd32: t = mk(7'h28, 1'b1, 4'd10, pk(80'("[27;_;40~"), 9));
			6'd33: t = mk(7'h29, 1'b1, 4'd10, pk(80'("[27;_;41~"), 9));
			6'd34: t = mk(7'h2B, 1'b1, 4'd10, pk(80'("[27;_;43~"), 9));
			6'd35: t = mk(7'h2C, 1'b1, 4'd10, pk(80'("[27;_;44~"), 9));
			6'd36: t = mk(7'h2D, 1'b1, 4'd10, pk(80'("[27;_;45~"), 9));
			6'd37: t = mk(7'h2E, 1'b1, 4'd10, pk(80'("[27;_;46~"), 9));
			6'd38: t = mk(7'h30, 1'b1, 4'd10, pk(80'("[27;_;48~"), 9));
			6'd39: t = mk(7'h31, 1'b1, 4'd10, pk(80'("[27;_;49~"), 9));
			6'd40: t = mk(7'h32, 1'b1, 4'd10, pk(80'("[27;_;50~"), 9));
			6'd41: t = mk(7'h33, 1'b1, 4'd10, pk(80'("[27;_;51~"), 9));
			6'd42: t = mk(7'h34, 1'b1, 4'd10, pk(80'("[27;_;52~"), 9));
			6'd43: t = mk(7'h35, 1'b1, 4'd10, pk(80'("[27;_;53~"), 9));
			6'd44: t = mk(7'h36, 1'b1, 4'd10, pk(80'("[27;_;54~"), 9));
			6'd45: t = mk(7'h37, 1'b1, 4'd10, pk(80'("[27;_;55~"), 9));
			6'd46: t = mk(7'h38, 1'b1, 4'd10, pk(80'("[27;_;56~"), 9));
			6'd47: t = mk(7'h39, 1'b1, 4'd10, pk(80'("[27;_;57~"), 9));
			6'd48: t = mk(7'h3A, 1'b1, 4'd10, pk(80'("[27;_;58~"), 9));
			6'd49: t = mk(7'h3B, 1'b1, 4'd10, pk(80'("[27;_;59~"), 9));
			6'd50: t = mk(7'h3C, 1'b1, 4'd10, pk(80'("[27;_;60~"), 9));
			6'd51: t = mk(7'h3D, 1'b1, 4'd10, pk(80'("[27;_;61~"), 9));
			6'd52: t = mk(7'h3E, 1'b1, 4'd10, pk(80'("[27;_;62~"), 9));
			6'd53: t = mk(7'h3F, 1'b1, 4'd10, pk(80'("[27;_;63~"), 9));
			6'd54: t = mk(7'h27, 1'b1, 4'd10, pk(80'("[27;_;39~"), 9));
			6'd55: t = mk(7'd13, 1'b1, 4'd10, pk(80'("[27;_;13~"), 9));
			6'd56: t = mk(7'd9, 1'b1, 4'd9, pk(80'("[27;_;9~"), 8));
			default: t = mk(7'd0, 1'b0, 4'd0, '0);
		endcase
		return t;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_0) && (b <= CH_9);
	endfunction

endpackage

// ----- design/xksm_stream_if.sv -----
// xksm_stream_if: valid/ready channel carrying one payload word
// depends on nothing; payload type given as a parameter
interface xksm_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/xterm_key_sequence_matcher_core.sv -----
// xterm_key_sequence_matcher_core: buffers terminal bytes and decodes
// xterm modified-key sequences; depends on xksm_pkg, xksm_stream_if, xksm_walker
// per byte: kick, then a template walk that reads the buffer memory byte by byte
// for each template tried, then the result is held until out_ch takes it
// throughput: one byte at a time; no new byte is accepted until that result is taken
// reset: asynchronous, clears the byte count and control; buffer is not cleared
module xterm_key_sequence_matcher_core #(
	parameter int unsigned MAX_SEQ = xksm_pkg::MaxSeqDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	xksm_stream_if.sink         in_ch,
	xksm_stream_if.source       out_ch
);
	import xksm_pkg::*;

	localparam int unsigned AW = $clog2(MAX_SEQ);
	localparam int unsigned CW = $clog2(MAX_SEQ + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_OUT  = 4'b0100,
		S_KICK = 4'b1000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [7:0]      mem [MAX_SEQ];
	logic [7:0]      rd_data_q;
	logic [AW-1:0]   rd_addr;
	logic            rd_en;
	logic            w_done;
	result_t         w_result;
	result_t         out_q;
	logic            in_acc;
	logic [CW-1:0]   base;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data = out_q;
	assign base = in_ch.data.seq_start ? '0 : count_q;

	// sequence buffer memory
	always_ff @(posedge clk) begin
		if (in_acc && base < CW'(MAX_SEQ)) mem[base[AW-1:0]] <= in_ch.data.data_byte;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// byte count and transaction control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_acc) begin
					count_q <= (base < CW'(MAX_SEQ)) ? base + CW'(1) : base;
					state_q <= S_KICK;
				end
				S_KICK: state_q <= S_WALK;
				S_WALK: if (w_done) state_q <= S_OUT;
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (w_done) out_q <= w_result;
	end

	xksm_walker #(.MAX_SEQ(MAX_SEQ), .AW(AW), .CW(CW)) u_walker (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == S_KICK),
		.seq_len(count_q),
		.rd_addr(rd_addr),
		.rd_en(rd_en),
		.rd_data(rd_data_q),
		.done(w_done),
		.result(w_result)
	);

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SEQ)) else $error("count overflow");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
	a_done_walk: assert property (@(posedge clk) disable iff (!arst_n)
		w_done |-> state_q == S_WALK) else $error("walker done outside walk");
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_q.status != 2'd3) else $error("bad status");
`endif
endmodule

// ----- design/xksm_walker.sv -----
// xksm_walker: walks the template table against the sequence buffer,
// one buffer byte at a time, in a read state then an evaluate state; depends on xksm_pkg
module xksm_walker #(
	parameter int unsigned MAX_SEQ = xksm_pkg::MaxSeqDefault,
	parameter int unsigned AW = $clog2(MAX_SEQ),
	parameter int unsigned CW = $clog2(MAX_SEQ + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [CW-1:0]           seq_len,
	output logic [AW-1:0]           rd_addr,
	output logic                    rd_en,
	input  logic [7:0]              rd_data,
	output logic                    done,
	output xksm_pkg::result_t       result
);
	import xksm_pkg::*;

	typedef enum logic [3:0] {
		W_IDLE = 4'b0001,
		W_READ = 4'b0010,
		W_EVAL = 4'b0100,
		W_DONE = 4'b1000
	} wstate_t;

	wstate_t            state_q;
	logic [TidxW-1:0]   tidx_q;
	logic [TposW-1:0]   ti_q;
	logic [CW-1:0]      pos_q;
	logic               in_wild_q;
	logic [3:0]         wval_q;
	logic [2:0]         mods_q;
	result_t            result_q;

	tmpl_t              tm;
	logic [7:0]         tc;
	logic [3:0]         v1;
	logic [2:0]         md;

	assign tm = tmpl_rom(tidx_q);
	assign tc = tm.chars[8*ti_q +: 8];
	assign rd_addr = pos_q[AW-1:0];
	assign rd_en = (state_q == W_READ);
	assign done = (state_q == W_DONE);
	assign result = result_q;

	// modifier bits from a one or two digit value, v - 1 wraps
	function automatic logic [2:0] mods_of(input logic [6:0] v);
		logic [6:0] c;
		c = v - 7'd1;
		return {c[2], c[1] | c[3], c[0]};
	endfunction

	assign v1 = rd_data[3:0];
	assign md = mods_of(7'(wval_q) * 7'd10 + 7'(v1));

	// walker sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			tidx_q <= '0;
			ti_q <= '0;
			pos_q <= '0;
			in_wild_q <= 1'b0;
			wval_q <= '0;
			mods_q <= '0;
			result_q <= '0;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (start) begin
						tidx_q <= '0;
						ti_q <= '0;
						pos_q <= '0;
						in_wild_q <= 1'b0;
						mods_q <= '0;
						if (seq_len == '0) begin
							result_q <= {ST_MATCH, 16'd0};
							state_q <= W_DONE;
						end else begin
							result_q <= '0;
							state_q <= W_READ;
						end
					end
				end
				W_READ: state_q <= W_EVAL;
				W_EVAL: begin
					logic fail, adv, second;
					logic [CW-1:0] npos;
					logic [2:0] nm;
					fail = 1'b0;
					adv = 1'b0;
					second = 1'b0;
					npos = pos_q + CW'(1);
					nm = mods_q;
					if (in_wild_q) begin
						// second wildcard byte, optional digit
						if (is_digit(rd_data)) begin
							nm = md;
						end else begin
							nm = mods_of(7'(wval_q));
							npos = pos_q;
						end
						adv = 1'b1;
					end else if (tc == WILD) begin
						if (seq_len - pos_q < CW'(2)) begin
							result_q.status <= ST_PARTIAL;
							state_q <= W_DONE;
						end else if (!is_digit(rd_data)) begin
							fail = 1'b1;
						end else begin
							second = 1'b1;
						end
					end else if (rd_data != tc) begin
						fail = 1'b0 | 1'b1;
					end else begin
						adv = 1'b1;
					end
					if (second) begin
						wval_q <= v1;
						in_wild_q <= 1'b1;
						pos_q <= npos;
						state_q <= W_READ;
					end else if (fail) begin
						if (tidx_q == TidxW'(NumTemplates - 1)) begin
							result_q.status <= ST_NONE;
							state_q <= W_DONE;
						end else begin
							tidx_q <= tidx_q + TidxW'(1);
							ti_q <= '0;
							pos_q <= '0;
							mods_q <= '0;
							state_q <= W_READ;
						end
					end else if (adv) begin
						in_wild_q <= 1'b0;
						mods_q <= nm;
						pos_q <= npos;
						ti_q <= ti_q + TposW'(1);
						if (ti_q + TposW'(1) == tm.len) begin
							result_q.status <= ST_MATCH;
							result_q.is_char <= tm.is_char;
							result_q.code <= tm.code;
							result_q.mods <= nm;
							result_q.used <= 5'(npos);
							state_q <= W_DONE;
						end else if (npos == seq_len) begin
							result_q.status <= ST_PARTIAL;
							state_q <= W_DONE;
						end else begin
							state_q <= W_READ;
						end
					end
				end
				W_DONE: state_q <= W_IDLE;
				default: state_q <= W_IDLE;
			endcase
		end
	end
endmodule

// ----- dv/xterm_key_sequence_matcher_core_tb.sv -----
// testbench for xterm_key_sequence_matcher_core: key escape sequences and noise in,
// decoded key results checked against a behavioral decoder; needs xksm_pkg, xksm_stream_if
`timescale 1ns / 1ps

module xterm_key_sequence_matcher_core_tb;
	import xksm_pkg::*;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       seq_start;
	} key_in_t;

	localparam int unsigned BufDepth = MaxSeqDefault;
	localparam longint CycleLimit = 4_000_000;
	localparam int unsigned DrainCycles = 1000;

	// keystroke decoder and the queue of decoded keys still owed by the block
	class key_scoreboard;
		string pat[NumTemplates];
		int unsigned kcode[NumTemplates];
		bit kchar[NumTemplates];
		logic [7:0] seq_mem[BufDepth];
		int unsigned seq_cnt;
		result_t pending[$];
		int unsigned errors;

		function new();
			pat = '{"\033[1;_P", "\033O1;_P", "\033O_P", "\033[1;_Q", "\033O1;_Q", "\033O_Q",
				"\033[1;_R", "\033O1;_R", "\033O_R", "\033[1;_S", "\033O1;_S", "\033O_S",
				"\033[15;_~", "\033[17;_~", "\033[18;_~", "\033[19;_~", "\033[20;_~",
				"\033[21;_~", "\033[23;_~", "\033[24;_~", "\033[1;_A", "\033[1;_B",
				"\033[1;_C", "\033[1;_D", "\033[1;_H", "\033[1;_F", "\033[5;_~",
				"\033[6;_~", "\033[2;_~", "\033[3;_~",
				"\033[27;_;33~", "\033[27;_;35~", "\033[27;_;40~", "\033[27;_;41~",
				"\033[27;_;43~", "\033[27;_;44~", "\033[27;_;45~", "\033[27;_;46~",
				"\033[27;_;48~", "\033[27;_;49~", "\033[27;_;50~", "\033[27;_;51~",
				"\033[27;_;52~", "\033[27;_;53~", "\033[27;_;54~", "\033[27;_;55~",
				"\033[27;_;56~", "\033[27;_;57~", "\033[27;_;58~", "\033[27;_;59~",
				"\033[27;_;60~", "\033[27;_;61~", "\033[27;_;62~", "\033[27;_;63~",
				"\033[27;_;39~", "\033[27;_;13~", "\033[27;_;9~"};
			kcode = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3, 4, 5, 6, 7, 8, 9, 10, 11,
				12, 13, 14, 15, 16, 17, 18, 19, 20, 21,
				33, 35, 40, 41, 43, 44, 45, 46, 48, 49, 50, 51, 52, 53, 54, 55,
				56, 57, 58, 59, 60, 61, 62, 63, 39, 13, 9};
			foreach (kchar[k]) kchar[k] = (k >= 30);
			seq_cnt = 0;
			errors = 0;
		endfunction

		// one template against the stored bytes: status, consumed bytes, modifiers
		function logic [1:0] try_one(int k, output int unsigned used, output logic [2:0] mods);
			int unsigned pos, i, v;
			logic [7:0] c;
			pos = 0;
			i = 0;
			used = 0;
			mods = '0;
			if (seq_cnt == 0) return ST_MATCH;
			forever begin
				c = pat[k][i];
				if (c == WILD) begin
					if (seq_cnt - pos < 2) return ST_PARTIAL;
					if (!is_dig(seq_mem[pos])) return ST_NONE;
					v = seq_mem[pos] - CH_0;
					pos++;
					if (is_dig(seq_mem[pos])) begin
						v = v * 10 + (seq_mem[pos] - CH_0);
						pos++;
					end
					v = v - 1;
					mods = {v[2], v[1] | v[3], v[0]};
				end else begin
					if (seq_mem[pos] != c) return ST_NONE;
					pos++;
				end
				i++;
				if (i == pat[k].len() || pos == seq_cnt) break;
			end
			if (i != pat[k].len()) return ST_PARTIAL;
			used = pos;
			return ST_MATCH;
		endfunction

		function bit is_dig(logic [7:0] b);
			return b >= CH_0 && b <= CH_9;
		endfunction

		// store the byte and decode the buffer as it now stands
		function void note_byte(key_in_t t);
			result_t r;
			logic [1:0] st;
			int unsigned used;
			logic [2:0] mods;
			if (t.seq_start) seq_cnt = 0;
			if (seq_cnt < BufDepth) begin
				seq_mem[seq_cnt] = t.data_byte;
				seq_cnt++;
			end
			r = '0;
			r.status = ST_NONE;
			for (int k = 0; k < NumTemplates; k++) begin
				st = try_one(k, used, mods);
				if (st == ST_NONE) continue;
				r.status = st;
				if (st == ST_MATCH) begin
					r.is_char = kchar[k];
					r.code = kcode[k][6:0];
					r.mods = mods;
					r.used = used[4:0];
				end
				break;
			end
			pending.push_back(r);
		endfunction

		function void check_key(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.is_char !== want.is_char ||
					got.code !== want.code || got.mods !== want.mods ||
					got.used !== want.used) begin
				errors++;
				if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	xksm_stream_if #(.payload_t(key_in_t)) in_ch ();
	xksm_stream_if #(.payload_t(result_t)) out_ch ();

	xterm_key_sequence_matcher_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));

	key_scoreboard sb = new();
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int unsigned hold_left = 0;
	longint cycles = 0;
	int unsigned n_items = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("xterm_key_sequence_matcher_core_tb: done, errors");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left <= 3000;
			hold_done <= 1'b1;
		end else if (hold_left != 0) hold_left <= hold_left - 1;
		if (hold_left > 1 || (hold_req && !hold_done)) out_ch.ready <= 1'b0;
		else out_ch.ready <= no_idle || ($urandom_range(99) >= 7);
	end

	// result check on every accepted transaction
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_key(out_ch.data);
	end

	task automatic send_byte(logic [7:0] b, logic s);
		key_in_t t;
		t.data_byte = b;
		t.seq_start = s;
		while (!no_idle && $urandom_range(99) < 7) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= t;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_byte(t);
		n_items++;
	endtask

	task automatic send_text(string s, int unsigned from = 0);
		for (int i = from; i < s.len(); i++) send_byte(s[i], i == from);
	endtask

	// well-formed template with a random modifier code, sometimes damaged
	task automatic send_key_seq();
		string p, s, m;
		int unsigned k, v, cut;
		k = $urandom_range(NumTemplates - 1);
		p = sb.pat[k];
		v = ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(16);
		m = $sformatf("%0d", v);
		if ($urandom_range(9) == 0 && v < 10) m = {"0", m};
		s = "";
		for (int i = 0; i < p.len(); i++) s = (p[i] == "_") ? {s, m} : {s, p.substr(i, i)};
		if ($urandom_range(6) == 0) s[$urandom_range(s.len() - 1)] = $urandom_range(255);
		if ($urandom_range(4) == 0)
			for (int j = $urandom_range(1, 6); j > 0; j--) s = {s, "x"};
		cut = ($urandom_range(9) == 0) ? $urandom_range(1, s.len()) : s.len();
		for (int i = 0; i < cut; i++) send_byte(s[i], i == 0);
	endtask

	task automatic send_noise();
		int unsigned n;
		n = $urandom_range(1, 22);
		for (int i = 0; i < n; i++)
			send_byte($urandom_range(255),
				(i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(30) == 0));
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero modifier wrap, two-digit code with trailing byte, bad digit
		send_text("\033O0P");
		send_text("\033[27;16;9~x");
		send_text("\033[1;A");
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);

		// random: mostly key sequences, some noise, one stretch without random stalls, one hold-off
		while (n_items < 930) begin
			no_idle = (n_items > 300 && n_items < 420);
			if (n_items > 600 && n_items < 640 && !hold_req) hold_req = 1'b1;
			if ($urandom_range(9) < 8) send_key_seq();
			else send_noise();
		end
		in_ch.valid <= 1'b0;
		hold_req = 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0) $display("xterm_key_sequence_matcher_core_tb: done, clean");
		else $display("xterm_key_sequence_matcher_core_tb: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
design/xksm_pkg.sv
design/xksm_stream_if.sv
design/xksm_walker.sv
design/xterm_key_sequence_matcher_core.sv
dv/xterm_key_sequence_matcher_core_tb.sv
